// ----- design/tlc_pkg.sv -----
// Shared constants and types for the taxonomic level confidence block.
package tlc_pkg;

  localparam int MAX_REFS   = 4;
  localparam int MAX_ROWS   = 512;
  localparam int MAX_LEVELS = 8;

  localparam int SLOT_W  = 2;
  localparam int ROWS_W  = 10;
  localparam int LEV_W   = 3;
  localparam int NL_W    = 4;
  localparam int CNT_W   = 16;
  localparam int BIT_W   = 16;
  localparam int CONF_W  = 17;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_LEVELS);
  localparam int ADDR_W  = SLOT_W + ROW_W + COL_W;
  localparam int SUM_W   = 20;
  localparam int REM_W   = SUM_W + 1;
  localparam int DSTEP_W = 5;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

endpackage

// ----- design/tlc_if.sv -----
// Valid/ready channel interfaces for request and result beats.
interface tlc_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [tlc_pkg::SLOT_W-1:0]    ref_slot;
  logic [tlc_pkg::ROWS_W-1:0]    score_row;
  logic [tlc_pkg::LEV_W-1:0]     level;
  logic [tlc_pkg::CNT_W-1:0]     count;
  logic [tlc_pkg::BIT_W-1:0]     bit_score;
  logic [tlc_pkg::NL_W-1:0]      num_levels;

  modport source (output valid, req_type, ref_slot, score_row, level, count, bit_score,
                  num_levels, input ready);
  modport sink (input valid, req_type, ref_slot, score_row, level, count, bit_score,
                num_levels, output ready);
endinterface

interface tlc_res_if;
  logic                          valid;
  logic                          ready;
  logic [tlc_pkg::LEV_W-1:0]     level_index;
  logic [tlc_pkg::CONF_W-1:0]    confidence;
  logic                          last;

  modport source (output valid, level_index, confidence, last, input ready);
  modport sink (input valid, level_index, confidence, last, output ready);
endinterface

// ----- design/tlc_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module tlc_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tlc_div.sv -----
// Restoring divider producing a 17-bit Q1.16 quotient, one bit per cycle.
module tlc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tlc_pkg::SUM_W-1:0]  num,
  input  logic [tlc_pkg::SUM_W-1:0]  den,
  output logic                       done,
  output logic [tlc_pkg::CONF_W-1:0] quo
);

  logic [tlc_pkg::REM_W-1:0]   rem;
  logic [tlc_pkg::SUM_W-1:0]   den_r;
  logic [tlc_pkg::DSTEP_W-1:0] step;
  logic                        running;
  logic                        ge;
  logic [tlc_pkg::REM_W-1:0]   diff_rem;

  assign ge       = rem >= {1'b0, den_r};
  assign diff_rem = ge ? rem - {1'b0, den_r} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem     <= {1'b0, num};
        den_r   <= den;
        step    <= '0;
        quo     <= '0;
      end else if (running) begin
        quo  <= {quo[tlc_pkg::CONF_W-2:0], ge};
        // The remainder stays below the divisor, so the top bit drops safely.
        rem  <= {diff_rem[tlc_pkg::SUM_W-1:0], 1'b0};
        step <= step + 1'b1;
        if (step == tlc_pkg::DSTEP_W'(tlc_pkg::CONF_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/taxonomic_level_confidence_top.sv -----
// Top level: request sequencer around the count table RAM and the divider.
// Load writes in idle. Fill walks each level from the last row in use back to the first, reading
// and writing each row. Query sums every level's count at the bit-score row, then per result reads
// the top and bit-score rows and divides; zero sums skip the divider, an empty slot every read.
// One request is worked at a time, set by the single RAM read port and the bit-serial divider.
// Reset: synchronous; then all 16384 entries are cleared one a cycle, with no request taken.
module taxonomic_level_confidence_top (
  input logic      clk,
  input logic      rst,
  tlc_req_if.sink  req_ch,
  tlc_res_if.source res_ch
);

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_F_RD  = 11'b00000000100,
    S_F_WR  = 11'b00000001000,
    S_Q_SRD = 11'b00000010000,
    S_Q_SAC = 11'b00000100000,
    S_Q_TRD = 11'b00001000000,
    S_Q_ARD = 11'b00010000000,
    S_Q_ACC = 11'b00100000000,
    S_Q_DIV = 11'b01000000000,
    S_Q_OUT = 11'b10000000000
  } state_t;

  state_t state;

  logic [tlc_pkg::ROWS_W-1:0]  rows_in_use [tlc_pkg::MAX_REFS];
  logic [tlc_pkg::ADDR_W-1:0]  clr_addr;
  logic [tlc_pkg::SLOT_W-1:0]  slot;
  logic [tlc_pkg::NL_W-1:0]    nl;
  logic [tlc_pkg::ROWS_W-1:0]  rows_q;
  logic [tlc_pkg::ROWS_W-1:0]  row_cnt;
  logic [tlc_pkg::ROWS_W-1:0]  b_row;
  logic [tlc_pkg::NL_W-1:0]    lev_cnt;
  logic [tlc_pkg::CNT_W-1:0]   held;
  logic [tlc_pkg::CNT_W-1:0]   top_val;
  logic [tlc_pkg::SUM_W-1:0]   same;
  logic [tlc_pkg::SUM_W-1:0]   diff;
  logic [tlc_pkg::CONF_W-1:0]  conf;
  logic                        empty;

  logic                        we;
  logic [tlc_pkg::ADDR_W-1:0]  waddr;
  logic [tlc_pkg::CNT_W-1:0]   wdata;
  logic [tlc_pkg::ADDR_W-1:0]  raddr;
  logic [tlc_pkg::CNT_W-1:0]   rdata;

  logic                        accept;
  logic                        out_hs;
  logic [tlc_pkg::NL_W-1:0]    nl_in;
  logic [tlc_pkg::ROWS_W-1:0]  rows_sel;
  logic [tlc_pkg::ROWS_W-1:0]  load_row_m1;
  logic                        load_ok;
  logic [tlc_pkg::BIT_W-1:0]   bit_fix;
  logic [tlc_pkg::ROWS_W-1:0]  b_in;
  logic [tlc_pkg::ROWS_W-1:0]  fill_row_m1;
  logic [tlc_pkg::ROWS_W-1:0]  b_row_m1;
  logic [tlc_pkg::CNT_W-1:0]   term;
  logic [tlc_pkg::SUM_W-1:0]   same_next;
  logic [tlc_pkg::SUM_W-1:0]   diff_next;
  logic [tlc_pkg::SUM_W-1:0]   den;
  logic                        div_start;
  logic                        div_done;
  logic [tlc_pkg::CONF_W-1:0]  div_quo;
  logic                        is_last;

  assign accept = req_ch.valid && req_ch.ready;
  assign out_hs = res_ch.valid && res_ch.ready;
  assign req_ch.ready = (state == S_IDLE);

  always_comb begin
    if (req_ch.num_levels < tlc_pkg::NL_W'(2)) begin
      nl_in = tlc_pkg::NL_W'(2);
    end else if (req_ch.num_levels > tlc_pkg::NL_W'(tlc_pkg::MAX_LEVELS)) begin
      nl_in = tlc_pkg::NL_W'(tlc_pkg::MAX_LEVELS);
    end else begin
      nl_in = req_ch.num_levels;
    end
  end

  assign rows_sel    = rows_in_use[req_ch.ref_slot];
  assign load_row_m1 = req_ch.score_row - 1'b1;
  assign load_ok     = (req_ch.score_row != '0) &&
                       (req_ch.score_row <= tlc_pkg::ROWS_W'(tlc_pkg::MAX_ROWS));
  assign bit_fix     = (req_ch.bit_score == '0) ? tlc_pkg::BIT_W'(1) : req_ch.bit_score;
  assign b_in        = (bit_fix > tlc_pkg::BIT_W'(rows_sel)) ? rows_sel
                                                              : bit_fix[tlc_pkg::ROWS_W-1:0];
  assign fill_row_m1 = row_cnt - 1'b1;
  assign b_row_m1    = b_row - 1'b1;

  always_comb begin
    case (state)
      S_F_RD:  raddr = {slot, fill_row_m1[tlc_pkg::ROW_W-1:0], lev_cnt[tlc_pkg::COL_W-1:0]};
      S_Q_TRD: raddr = {slot, {tlc_pkg::ROW_W{1'b0}}, lev_cnt[tlc_pkg::COL_W-1:0]};
      default: raddr = {slot, b_row_m1[tlc_pkg::ROW_W-1:0], lev_cnt[tlc_pkg::COL_W-1:0]};
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    case (state)
      S_CLR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        we    = accept && (req_ch.req_type == tlc_pkg::REQ_LOAD) && load_ok;
        waddr = {req_ch.ref_slot, load_row_m1[tlc_pkg::ROW_W-1:0],
                 req_ch.level[tlc_pkg::COL_W-1:0]};
        wdata = req_ch.count;
      end
      S_F_WR: begin
        we    = (rdata == '0);
        waddr = {slot, fill_row_m1[tlc_pkg::ROW_W-1:0], lev_cnt[tlc_pkg::COL_W-1:0]};
        wdata = held;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Clamped same-term: a count that grew below the top row adds nothing.
  assign term      = (top_val > rdata) ? top_val - rdata : '0;
  assign same_next = same + tlc_pkg::SUM_W'(term);
  assign diff_next = diff - tlc_pkg::SUM_W'(rdata);
  assign den       = same_next + diff_next;
  assign div_start = (state == S_Q_ACC) && (den != '0);
  assign is_last   = (lev_cnt == nl - tlc_pkg::NL_W'(2));

  tlc_ram #(
    .DATA_W (tlc_pkg::CNT_W),
    .ADDR_W (tlc_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tlc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (same_next),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      for (int k = 0; k < tlc_pkg::MAX_REFS; k++) begin
        rows_in_use[k] <= '0;
      end
    end else begin
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {tlc_pkg::ADDR_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            slot    <= req_ch.ref_slot;
            nl      <= nl_in;
            rows_q  <= rows_sel;
            row_cnt <= rows_sel;
            b_row   <= b_in;
            lev_cnt <= '0;
            held    <= '0;
            diff    <= '0;
            same    <= '0;
            conf    <= '0;
            empty   <= (rows_sel == '0);
            case (req_ch.req_type)
              tlc_pkg::REQ_LOAD: begin
                if (load_ok && (req_ch.score_row > rows_sel)) begin
                  rows_in_use[req_ch.ref_slot] <= req_ch.score_row;
                end
              end
              tlc_pkg::REQ_FILL: begin
                if (rows_sel != '0) begin
                  state <= S_F_RD;
                end
              end
              tlc_pkg::REQ_QUERY: begin
                state <= (rows_sel == '0) ? S_Q_OUT : S_Q_SRD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_F_RD: begin
          state <= S_F_WR;
        end
        S_F_WR: begin
          if (rdata != '0) begin
            held <= rdata;
          end
          state <= S_F_RD;
          if (row_cnt == tlc_pkg::ROWS_W'(1)) begin
            row_cnt <= rows_q;
            held    <= '0;
            lev_cnt <= lev_cnt + 1'b1;
            if (lev_cnt == nl - 1'b1) begin
              state <= S_IDLE;
            end
          end else begin
            row_cnt <= row_cnt - 1'b1;
          end
        end
        S_Q_SRD: begin
          state <= S_Q_SAC;
        end
        S_Q_SAC: begin
          diff <= diff + tlc_pkg::SUM_W'(rdata);
          if (lev_cnt == nl - 1'b1) begin
            lev_cnt <= '0;
            state   <= S_Q_TRD;
          end else begin
            lev_cnt <= lev_cnt + 1'b1;
            state   <= S_Q_SRD;
          end
        end
        S_Q_TRD: begin
          state <= S_Q_ARD;
        end
        S_Q_ARD: begin
          top_val <= rdata;
          state   <= S_Q_ACC;
        end
        S_Q_ACC: begin
          same <= same_next;
          diff <= diff_next;
          if (den == '0) begin
            conf  <= '0;
            state <= S_Q_OUT;
          end else begin
            state <= S_Q_DIV;
          end
        end
        S_Q_DIV: begin
          if (div_done) begin
            conf  <= div_quo;
            state <= S_Q_OUT;
          end
        end
        S_Q_OUT: begin
          if (out_hs) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              lev_cnt <= lev_cnt + 1'b1;
              state   <= empty ? S_Q_OUT : S_Q_TRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_ch.valid       = (state == S_Q_OUT);
  assign res_ch.level_index = lev_cnt[tlc_pkg::LEV_W-1:0];
  assign res_ch.confidence  = conf;
  assign res_ch.last        = is_last;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the taxonomic level confidence block.
module tb_top;

  localparam int MAX_CYCLES = 10_000_000;
  localparam int DRAIN_CYCLES = 20_000;
  localparam int RANDOM_ITEMS = 350;

  typedef struct {
    tlc_pkg::req_t                     op;
    logic [tlc_pkg::SLOT_W-1:0]        slot;
    logic [tlc_pkg::ROWS_W-1:0]        row;
    logic [tlc_pkg::LEV_W-1:0]         lev;
    logic [tlc_pkg::CNT_W-1:0]         cnt;
    logic [tlc_pkg::BIT_W-1:0]         bits;
    logic [tlc_pkg::NL_W-1:0]          nl;
    bit                                has_conf;
    logic [tlc_pkg::CONF_W-1:0]        conf;
  } request_t;

  typedef struct {
    logic [tlc_pkg::LEV_W-1:0]  level_index;
    logic [tlc_pkg::CONF_W-1:0] confidence;
    logic                       last;
  } confidence_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_off = 1'b0;

  tlc_req_if req_ch();
  tlc_res_if res_ch();

  taxonomic_level_confidence_top dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch.sink),
    .res_ch (res_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the count tables.
  logic [tlc_pkg::CNT_W-1:0]  counts [tlc_pkg::MAX_REFS][tlc_pkg::MAX_ROWS][tlc_pkg::MAX_LEVELS];
  logic [tlc_pkg::ROWS_W-1:0] rows_used [tlc_pkg::MAX_REFS];

  confidence_t pending_conf[$];
  request_t    directed[$];
  int          mismatches = 0;
  int          phase = 0;
  longint      cycles = 0;

  function automatic void add_row(request_t rq);
    directed.insert(directed.size(), rq);
  endfunction

  function automatic int levels_taken(logic [tlc_pkg::NL_W-1:0] nl);
    if (nl < 2) return 2;
    if (nl > tlc_pkg::MAX_LEVELS) return tlc_pkg::MAX_LEVELS;
    return int'(nl);
  endfunction

  // Applies one accepted request to the shadow tables and queues its confidences.
  task automatic predict_request(request_t rq);
    int nl;
    int rows;
    int b;
    longint same;
    longint diff;
    longint conf;
    confidence_t c;
    logic [tlc_pkg::CNT_W-1:0] held;
    nl = levels_taken(rq.nl);
    case (rq.op)
      tlc_pkg::REQ_LOAD: begin
        if (rq.row != 0 && rq.row <= tlc_pkg::MAX_ROWS) begin
          counts[rq.slot][rq.row-1][rq.lev] = rq.cnt;
          if (rq.row > rows_used[rq.slot]) rows_used[rq.slot] = rq.row;
        end
      end
      tlc_pkg::REQ_FILL: begin
        for (int col = 0; col < nl; col++) begin
          held = '0;
          for (int r = rows_used[rq.slot]; r > 0; r--) begin
            if (counts[rq.slot][r-1][col] != 0) held = counts[rq.slot][r-1][col];
            else counts[rq.slot][r-1][col] = held;
          end
        end
      end
      tlc_pkg::REQ_QUERY: begin
        rows = rows_used[rq.slot];
        b = (rq.bits == 0) ? 1 : int'(rq.bits);
        if (b > rows) b = rows;
        for (int i = 0; i + 1 < nl; i++) begin
          conf = 0;
          if (rows != 0) begin
            same = 0;
            diff = 0;
            for (int j = 0; j < nl; j++) begin
              if (j <= i) begin
                if (counts[rq.slot][0][j] > counts[rq.slot][b-1][j])
                  same += counts[rq.slot][0][j] - counts[rq.slot][b-1][j];
              end else begin
                diff += counts[rq.slot][b-1][j];
              end
            end
            if (same + diff != 0) conf = (same << 16) / (same + diff);
          end
          c.level_index = i[tlc_pkg::LEV_W-1:0];
          c.confidence  = rq.has_conf ? rq.conf : conf[tlc_pkg::CONF_W-1:0];
          c.last        = (i + 2 == nl);
          pending_conf.insert(pending_conf.size(), c);
        end
      end
      default: ;
    endcase
  endtask

  function automatic request_t make_request(tlc_pkg::req_t op, int slot, int row, int lev,
                                            int cnt, int bits, int nl);
    request_t rq;
    rq.op = op;
    rq.slot = slot[tlc_pkg::SLOT_W-1:0];
    rq.row = row[tlc_pkg::ROWS_W-1:0];
    rq.lev = lev[tlc_pkg::LEV_W-1:0];
    rq.cnt = cnt[tlc_pkg::CNT_W-1:0];
    rq.bits = bits[tlc_pkg::BIT_W-1:0];
    rq.nl = nl[tlc_pkg::NL_W-1:0];
    rq.has_conf = 1'b0;
    rq.conf = '0;
    return rq;
  endfunction

  function automatic request_t query_known(int slot, int bits, int nl, int conf);
    request_t rq;
    rq = make_request(tlc_pkg::REQ_QUERY, slot, 0, 0, 0, bits, nl);
    rq.has_conf = 1'b1;
    rq.conf = conf[tlc_pkg::CONF_W-1:0];
    return rq;
  endfunction

  // Presents one request and returns once it has been accepted.
  task automatic send_request(request_t rq);
    while ((phase == 0 && $urandom_range(99) < 6) || (phase == 1 && $urandom_range(99) < 59))
    begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rq.op;
    req_ch.ref_slot   <= rq.slot;
    req_ch.score_row  <= rq.row;
    req_ch.level      <= rq.lev;
    req_ch.count      <= rq.cnt;
    req_ch.bit_score  <= rq.bits;
    req_ch.num_levels <= rq.nl;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_request(rq);
  endtask

  function automatic int pick_count();
    case ($urandom_range(5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(65535);
      default: return $urandom_range(200);
    endcase
  endfunction

  // Long receiver hold-off early in the last phase, so that the block backs up.
  initial begin
    wait (phase == 2);
    repeat (20) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Receiver: random back-pressure in the first two phases, plus the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_off) begin
      res_ch.ready <= 1'b0;
    end else if (phase == 0) begin
      res_ch.ready <= ($urandom_range(99) >= 59);
    end else if (phase == 1) begin
      res_ch.ready <= ($urandom_range(99) >= 6);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    confidence_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_conf.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: level %0d confidence %0d last %0d",
                   res_ch.level_index, res_ch.confidence, res_ch.last);
      end else begin
        want = pending_conf.pop_front();
        if (res_ch.level_index !== want.level_index || res_ch.confidence !== want.confidence ||
            res_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected level %0d conf %0d last %0d, got %0d %0d %0d",
                     want.level_index, want.confidence, want.last,
                     res_ch.level_index, res_ch.confidence, res_ch.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int sent;
    int slot;
    int top_row;
    req_ch.valid = 1'b0;
    req_ch.req_type = tlc_pkg::REQ_NONE;
    req_ch.ref_slot = '0;
    req_ch.score_row = '0;
    req_ch.level = '0;
    req_ch.count = '0;
    req_ch.bit_score = '0;
    req_ch.num_levels = '0;
    for (int s = 0; s < tlc_pkg::MAX_REFS; s++) begin
      rows_used[s] = '0;
      for (int r = 0; r < tlc_pkg::MAX_ROWS; r++)
        for (int l = 0; l < tlc_pkg::MAX_LEVELS; l++) counts[s][r][l] = '0;
    end

    // Empty slots, zero bit score and level count clamping both ways.
    add_row(query_known(0, 0, 0, 0));
    add_row(query_known(3, 65535, 15, 0));
    add_row(make_request(tlc_pkg::REQ_LOAD, 1, 1, 0, 100, 0, 0));
    // Same and different both zero.
    add_row(query_known(1, 1, 2, 0));
    // Bit score above the rows in use falls back to the last row in use.
    add_row(query_known(1, 2, 2, 0));
    add_row(make_request(tlc_pkg::REQ_LOAD, 1, 2, 1, 0, 0, 0));
    add_row(query_known(1, 2, 2, 65536));
    // Lower row larger than the top row: the same-term clamps at zero.
    add_row(make_request(tlc_pkg::REQ_LOAD, 1, 2, 0, 65535, 0, 0));
    add_row(query_known(1, 2, 2, 0));
    // Out-of-range rows are dropped; the largest row and level are kept.
    add_row(make_request(tlc_pkg::REQ_LOAD, 2, 0, 3, 77, 0, 0));
    add_row(make_request(tlc_pkg::REQ_LOAD, 2, 1023, 7, 77, 0, 0));
    add_row(make_request(tlc_pkg::REQ_LOAD, 2, 513, 2, 77, 0, 0));
    add_row(make_request(tlc_pkg::REQ_LOAD, 2, 512, 7, 65535, 0, 0));
    add_row(make_request(tlc_pkg::REQ_LOAD, 2, 1, 0, 40000, 0, 0));
    add_row(make_request(tlc_pkg::REQ_LOAD, 2, 300, 3, 9, 0, 0));
    add_row(make_request(tlc_pkg::REQ_FILL, 2, 0, 0, 0, 0, 15));
    add_row(make_request(tlc_pkg::REQ_QUERY, 2, 0, 0, 0, 512, 8));
    add_row(make_request(tlc_pkg::REQ_QUERY, 2, 0, 0, 0, 300, 8));
    add_row(make_request(tlc_pkg::REQ_NONE, 3, 1023, 7, 65535, 65535, 15));
    add_row(make_request(tlc_pkg::REQ_FILL, 1, 0, 0, 0, 0, 0));
    add_row(make_request(tlc_pkg::REQ_QUERY, 1, 0, 0, 0, 65535, 5));
    add_row(make_request(tlc_pkg::REQ_QUERY, 2, 0, 0, 0, 0, 3));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) send_request(directed[k]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS / 3) phase = 1;
      if (sent >= 2 * RANDOM_ITEMS / 3) phase = 2;
      slot = $urandom_range(3);
      top_row = ($urandom_range(39) == 0) ? tlc_pkg::MAX_ROWS : $urandom_range(1, 24);
      if ($urandom_range(9) == 0) begin
        // Noise: ignored types and out-of-range loads.
        send_request(make_request(tlc_pkg::REQ_NONE, slot, $urandom_range(1023),
                                  $urandom_range(7), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(15)));
        send_request(make_request(tlc_pkg::REQ_LOAD, slot, $urandom_range(513, 1023),
                                  $urandom_range(7), pick_count(), 0, 0));
        sent += 2;
      end else begin
        repeat ($urandom_range(2, 7)) begin
          send_request(make_request(tlc_pkg::REQ_LOAD, slot, $urandom_range(1, top_row),
                                    $urandom_range(7), pick_count(), 0, 0));
          sent++;
        end
        if ($urandom_range(2) != 0) begin
          send_request(make_request(tlc_pkg::REQ_FILL, slot, 0, 0, 0, 0, $urandom_range(15)));
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_request(make_request(tlc_pkg::REQ_QUERY, slot, 0, 0, 0,
                                    ($urandom_range(7) == 0) ? $urandom_range(65535)
                                                             : $urandom_range(top_row + 2),
                                    $urandom_range(15)));
          sent++;
        end
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_conf.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_conf.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- taxonomic_level_confidence_top.f -----
design/tlc_pkg.sv
design/tlc_if.sv
design/tlc_ram.sv
design/tlc_div.sv
design/taxonomic_level_confidence_top.sv
verif/tb_top.sv
